### sv/lagtc_pkg.sv
package lagtc_pkg;

	// day counters are taken in their low DAY_BITS bits
	localparam int DAY_BITS   = 20;
	localparam int LAG_W      = DAY_BITS + 1;
	localparam int LIMIT_W    = 10;
	localparam int HALF_W     = LIMIT_W - 1;
	localparam int PEN_W      = 16;
	localparam int PID_W      = 8;
	localparam int MDAY_W     = 5;
	localparam int SQ_W       = 2 * HALF_W;
	localparam int PROD_W     = PEN_W + SQ_W;
	localparam int DIV_STEPS  = PEN_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(10);
	localparam logic [PEN_W-1:0]   MAX_PEN_RESET = PEN_W'(1200);
	localparam logic [PEN_W-1:0]   SLEEP_MIN_MS  = PEN_W'(5);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE  = 2'd0,
		CFG_LIMIT   = 2'd1,
		CFG_MAX_PEN = 2'd2
	} cfg_index_t;

	typedef enum logic {
		OP_PING = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SQUARE,
		ST_SCALE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic eval;
		logic square;
		logic scale;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic tick_fire;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

### sv/lagtc_if.sv
interface lagtc_item_if;
	import lagtc_pkg::*;
	logic                valid;
	logic                ready;
	logic                op;
	logic [19:0]         report_day;
	logic [PID_W-1:0]    client_id;
	logic [MDAY_W-1:0]   month_day;
	logic [19:0]         total_days;

	modport source (output valid, op, report_day, client_id, month_day, total_days, input ready);
	modport sink (input valid, op, report_day, client_id, month_day, total_days, output ready);
endinterface

interface lagtc_result_if;
	import lagtc_pkg::*;
	logic                valid;
	logic                ready;
	logic [PEN_W-1:0]    penalty_ms;
	logic                sleep_now;
	logic                tracker_cleared;
	logic [PID_W-1:0]    lagging_player;

	modport source (output valid, penalty_ms, sleep_now, tracker_cleared, lagging_player,
		input ready);
	modport sink (input valid, penalty_ms, sleep_now, tracker_cleared, lagging_player,
		output ready);
endinterface

### sv/lagtc_ctrl.sv
module lagtc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  lagtc_pkg::status_t  sts,
	output logic                in_ready,
	output lagtc_pkg::cmd_t     cmd
);
	import lagtc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && sts.tick_fire) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for a free output slot
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### sv/lagtc_dp.sv
module lagtc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lagtc_pkg::cmd_t                    cmd,
	output lagtc_pkg::status_t                 sts,
	input  logic                               cfg_wr_en,
	input  logic [lagtc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lagtc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               in_op,
	input  logic [19:0]                        in_report_day,
	input  logic [lagtc_pkg::PID_W-1:0]        in_client_id,
	input  logic [lagtc_pkg::MDAY_W-1:0]       in_month_day,
	input  logic [19:0]                        in_total_days,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [lagtc_pkg::PEN_W-1:0]        out_penalty_ms,
	output logic                               out_sleep_now,
	output logic                               out_tracker_cleared,
	output logic [lagtc_pkg::PID_W-1:0]        out_lagging_player
);
	import lagtc_pkg::*;

	// configuration
	logic                enable_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [PEN_W-1:0]    max_pen_q;

	// tracker and day state
	logic                trk_valid_q;
	logic [DAY_BITS-1:0] oldest_day_q;
	logic [PID_W-1:0]    oldest_player_q;
	logic                last_valid_q;
	logic [MDAY_W-1:0]   last_mday_q;

	// arithmetic
	logic [LAG_W-1:0]    lag_q;
	logic [HALF_W-1:0]   excess_q;
	logic                zero_q;
	logic                sat_q;
	logic                cleared_q;
	logic [SQ_W-1:0]     sq_q;
	logic [SQ_W-1:0]     bsq_q;
	logic [SQ_W-1:0]     rem_q;
	logic [PEN_W-1:0]    dq_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                out_valid_q;
	logic [PEN_W-1:0]    pen_q;
	logic                sleep_q;
	logic                clr_q;
	logic [PID_W-1:0]    player_q;

	logic [DAY_BITS-1:0] rpt_day;
	logic [DAY_BITS-1:0] total_day;
	logic                ping_take;
	logic                tick_active;
	logic                tick_fire;
	logic [HALF_W-1:0]   half;
	logic [LIMIT_W-1:0]  thr;
	logic                lag_over;
	logic [LAG_W-1:0]    lag_eff;
	logic [LAG_W-1:0]    diff;
	logic                below;
	logic [HALF_W-1:0]   excess;
	logic [PROD_W-1:0]   prod;
	logic [SQ_W:0]       shifted;
	logic [SQ_W+1:0]     trial;
	logic                ge;
	logic [PEN_W-1:0]    pen;

	assign rpt_day   = in_report_day[DAY_BITS-1:0];
	assign total_day = in_total_days[DAY_BITS-1:0];

	assign ping_take = !trk_valid_q || (rpt_day < oldest_day_q) ||
		(in_client_id == oldest_player_q && rpt_day > oldest_day_q);

	assign tick_active = (in_op == OP_TICK) && enable_q && trk_valid_q;
	assign tick_fire   = tick_active && last_valid_q && (in_month_day != last_mday_q);

	// lag evaluation
	assign half     = limit_q[LIMIT_W-1:1];
	assign thr      = limit_q - {1'b0, half};
	assign lag_over = $signed(lag_q) > $signed({{(LAG_W-LIMIT_W){1'b0}}, limit_q});
	assign lag_eff  = lag_over ? '0 : lag_q;
	assign below    = $signed(lag_eff) < $signed({{(LAG_W-LIMIT_W){1'b0}}, thr});
	assign diff     = lag_eff - {{(LAG_W-LIMIT_W){1'b0}}, thr};
	assign excess   = diff[HALF_W-1:0];

	assign prod = {{SQ_W{1'b0}}, max_pen_q} * {{PEN_W{1'b0}}, sq_q};

	// restoring divide step, one quotient bit a cycle
	assign shifted = {rem_q, dq_q[PEN_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, bsq_q};
	assign ge      = !trial[SQ_W+1];

	assign pen = zero_q ? '0 : (sat_q ? max_pen_q : dq_q);

	assign sts.tick_fire = tick_fire;
	assign sts.div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b0;
			limit_q         <= LIMIT_RESET;
			max_pen_q       <= MAX_PEN_RESET;
			trk_valid_q     <= 1'b0;
			oldest_day_q    <= '0;
			oldest_player_q <= '0;
			last_valid_q    <= 1'b0;
			last_mday_q     <= '0;
			out_valid_q     <= 1'b0;
			cnt_q           <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_ENABLE:  enable_q  <= cfg_data[0];
					CFG_LIMIT:   limit_q   <= cfg_data[LIMIT_W-1:0];
					CFG_MAX_PEN: max_pen_q <= cfg_data[PEN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (in_op == OP_PING) begin
					if (ping_take) begin
						trk_valid_q     <= 1'b1;
						oldest_day_q    <= rpt_day;
						oldest_player_q <= in_client_id;
					end
				end else if (tick_active) begin
					if (!last_valid_q) begin
						last_valid_q <= 1'b1;
						last_mday_q  <= in_month_day;
					end else if (tick_fire) begin
						last_mday_q <= in_month_day;
					end
				end
			end
			if (cmd.eval && lag_over) begin
				trk_valid_q     <= 1'b0;
				oldest_day_q    <= '0;
				oldest_player_q <= '0;
			end
			if (cmd.scale) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lag_q <= {1'b0, total_day} - {1'b0, oldest_day_q};
		end
		if (cmd.eval) begin
			excess_q  <= excess;
			// no excess over the threshold gives no delay, also with a zero buffer
			zero_q    <= below || (excess == '0);
			// zero buffer: saturate only on a positive excess
			sat_q     <= (excess >= half) && (excess != '0);
			cleared_q <= lag_over;
		end
		if (cmd.square) begin
			sq_q  <= {{HALF_W{1'b0}}, excess_q} * {{HALF_W{1'b0}}, excess_q};
			bsq_q <= {{HALF_W{1'b0}}, half} * {{HALF_W{1'b0}}, half};
		end
		if (cmd.scale) begin
			rem_q <= prod[PROD_W-1:PEN_W];
			dq_q  <= prod[PEN_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial[SQ_W-1:0] : shifted[SQ_W-1:0];
			dq_q  <= {dq_q[PEN_W-2:0], ge};
		end
		if (cmd.out_load) begin
			pen_q    <= pen;
			sleep_q  <= pen > SLEEP_MIN_MS;
			clr_q    <= cleared_q;
			player_q <= oldest_player_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign out_penalty_ms      = pen_q;
	assign out_sleep_now       = sleep_q;
	assign out_tracker_cleared = clr_q;
	assign out_lagging_player  = player_q;

endmodule

### sv/lag_throttle_controller_unit.sv
// a ping is absorbed at its transfer; a new-day tick raises its result after evaluate, square,
// scale, 16 divide steps and a hand-off that waits while the output register is full
// throughput: one ping or plain tick a cycle; a new-day tick keeps the input not ready until
// its result is handed off, longer while the output register is full
// reset: arst_n clears config to defaults, empties the tracker and the day latch
module lag_throttle_controller_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [lagtc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lagtc_pkg::CFG_DATA_W-1:0]   cfg_data,
	lagtc_item_if.sink                         item,
	lagtc_result_if.source                     result
);
	import lagtc_pkg::*;

	cmd_t    cmd;
	status_t sts;
	logic    in_ready;

	// input side only ready while the sequencer is idle
	assign item.ready = in_ready;

	// sequencer: idle, then evaluate, square, scale, divide, hand off
	lagtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// tracker, config registers, penalty arithmetic and output register
	// the output register lets a finished result wait while new items transfer in
	lagtc_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_op               (item.op),
		.in_report_day       (item.report_day),
		.in_client_id        (item.client_id),
		.in_month_day        (item.month_day),
		.in_total_days       (item.total_days),
		.out_valid           (result.valid),
		.out_ready           (result.ready),
		.out_penalty_ms      (result.penalty_ms),
		.out_sleep_now       (result.sleep_now),
		.out_tracker_cleared (result.tracker_cleared),
		.out_lagging_player  (result.lagging_player)
	);

endmodule

### tb/lag_throttle_controller_unit_tb.sv
`timescale 1ns / 1ps

module lag_throttle_controller_unit_tb;
	import lagtc_pkg::*;

	// quiet cycles allowed before the run is declared hung; the longest
	// intended quiet stretch is the receiver hold-off below
	localparam int QUIET_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 300;
	// a result tick occupies the block until its hand-off, so this covers any tail
	localparam int SETTLE_CYCLES = 30;

	// one input item as the sender sees it
	typedef struct packed {
		op_t               op;
		logic [19:0]       report_day;
		logic [PID_W-1:0]  client_id;
		logic [MDAY_W-1:0] month_day;
		logic [19:0]       total_days;
	} lag_item_t;

	// one throttle decision as the block reports it
	typedef struct packed {
		logic [PEN_W-1:0] penalty_ms;
		logic             sleep_now;
		logic             tracker_cleared;
		logic [PID_W-1:0] lagging_player;
	} throttle_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lagtc_item_if   item_ch ();
	lagtc_result_if result_ch ();

	lag_throttle_controller_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	always #10 clk = ~clk;

	// shadow copy of the register file, starting at the reset defaults
	logic               thr_on    = 1'b0;
	logic [LIMIT_W-1:0] lag_limit = LIMIT_RESET;
	logic [PEN_W-1:0]   pen_cap   = MAX_PEN_RESET;

	// shadow copy of the lag tracker and the day-change latch
	logic               trk_valid    = 1'b0;
	logic [19:0]        trk_day      = '0;
	logic [PID_W-1:0]   trk_player   = '0;
	logic               day_latched  = 1'b0;
	logic [MDAY_W-1:0]  latched_mday = '0;

	// throttle decisions predicted but not yet seen on the result channel
	throttle_result_t expected_throttle[$];

	int mismatch_count = 0;

	// flow control knobs: steady turns off random idling, rx_hold is a
	// hold-off counted down by the receiver process
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_hold   = 0;

	// game clock used to build plausible ping/tick streams
	logic [19:0]       world_day;
	logic [MDAY_W-1:0] cur_mday;

	// quadratic delay over the buffer half of the limit
	function automatic logic [PEN_W-1:0] throttle_delay(int lag);
		int half;
		int knee;
		int excess;
		longint unsigned scaled;
		half = int'(lag_limit >> 1);
		knee = int'(lag_limit) - half;
		if (lag < knee)
			return '0;
		excess = lag - knee;
		// no buffer: step straight to full delay past the knee
		if (half == 0)
			return (excess > 0) ? pen_cap : '0;
		if (excess >= half)
			return pen_cap;
		scaled = longint'(pen_cap) * excess * excess / (half * half);
		return PEN_W'(scaled);
	endfunction

	// update the shadow tracker for one accepted item and queue any decision
	function automatic void predict_item(lag_item_t it);
		throttle_result_t res;
		int lag;
		if (it.op == OP_PING) begin
			// empty tracker, an older day, or the laggard moving ahead
			if (!trk_valid || it.report_day < trk_day ||
					(it.client_id == trk_player && it.report_day > trk_day)) begin
				trk_valid  = 1'b1;
				trk_day    = it.report_day;
				trk_player = it.client_id;
			end
			return;
		end
		// ticks are ignored outright while off or with nobody tracked
		if (!thr_on || !trk_valid)
			return;
		if (!day_latched) begin
			day_latched  = 1'b1;
			latched_mday = it.month_day;
			return;
		end
		if (it.month_day == latched_mday)
			return;
		latched_mday = it.month_day;
		lag = int'(it.total_days) - int'(trk_day);
		res.tracker_cleared = 1'b0;
		// too far behind: drop the laggard and treat the lag as none
		if (lag > int'(lag_limit)) begin
			lag                 = 0;
			res.tracker_cleared = 1'b1;
			trk_valid           = 1'b0;
			trk_day             = '0;
			trk_player          = '0;
		end
		res.penalty_ms     = throttle_delay(lag);
		res.sleep_now      = res.penalty_ms > SLEEP_MIN_MS;
		res.lagging_player = trk_player;
		expected_throttle.push_back(res);
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		$display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		mismatch_count++;
	endtask

	// one transfer on the item channel; entered and left at a falling edge,
	// valid stays high on return so back-to-back items need no gap
	task automatic send_item(lag_item_t it);
		if (!tx_steady) begin
			while ($urandom_range(0, 2) == 0) begin
				item_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		item_ch.valid      <= 1'b1;
		item_ch.op         <= it.op;
		item_ch.report_day <= it.report_day;
		item_ch.client_id  <= it.client_id;
		item_ch.month_day  <= it.month_day;
		item_ch.total_days <= it.total_days;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		predict_item(it);
		@(negedge clk);
	endtask

	task automatic send_ping(logic [19:0] day, logic [PID_W-1:0] pid);
		lag_item_t it;
		it.op         = OP_PING;
		it.report_day = day;
		it.client_id  = pid;
		it.month_day  = MDAY_W'($urandom);
		it.total_days = 20'($urandom);
		send_item(it);
	endtask

	task automatic send_tick(logic [MDAY_W-1:0] mday, logic [19:0] total);
		lag_item_t it;
		it.op         = OP_TICK;
		it.report_day = 20'($urandom);
		it.client_id  = PID_W'($urandom);
		it.month_day  = mday;
		it.total_days = total;
		send_item(it);
	endtask

	// stop offering items, wait for every pending decision, then let the
	// block finish any silent work before anything else happens
	task automatic settle();
		item_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_throttle.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_ENABLE:  thr_on    = data[0];
			CFG_LIMIT:   lag_limit = data[LIMIT_W-1:0];
			CFG_MAX_PEN: pen_cap   = data[PEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(logic en, logic [LIMIT_W-1:0] limit, logic [PEN_W-1:0] cap);
		settle();
		write_reg(CFG_ENABLE, CFG_DATA_W'(en));
		write_reg(CFG_LIMIT, CFG_DATA_W'(limit));
		write_reg(CFG_MAX_PEN, cap);
	endtask

	// game-paced stream: pings trail the game day by up to a bit more than
	// the limit, ticks mostly open a new day; noise_pct percent is garbage
	task automatic play_round(int count, int noise_pct);
		lag_item_t it;
		int span;
		for (int n = 0; n < count; n++) begin
			span = int'(lag_limit) + 4;
			if ($urandom_range(0, 99) < noise_pct) begin
				it.op         = op_t'($urandom_range(0, 1));
				it.report_day = 20'($urandom);
				it.client_id  = PID_W'($urandom);
				it.month_day  = MDAY_W'($urandom);
				it.total_days = 20'($urandom);
			end else if ($urandom_range(0, 99) < 55) begin
				it.op = OP_PING;
				// reuse the laggard often so it gets to move ahead
				it.client_id = ($urandom_range(0, 9) < 4) ? trk_player : PID_W'($urandom);
				if ($urandom_range(0, 9) == 0)
					it.report_day = world_day + 20'($urandom_range(0, 3));
				else
					it.report_day = world_day - 20'($urandom_range(0, span));
				it.month_day  = MDAY_W'($urandom);
				it.total_days = 20'($urandom);
			end else begin
				it.op = OP_TICK;
				if ($urandom_range(0, 99) < 85) begin
					cur_mday  = cur_mday + MDAY_W'(1);
					world_day = world_day + 20'($urandom_range(0, 2));
				end
				it.month_day  = cur_mday;
				it.total_days = world_day;
				it.report_day = 20'($urandom);
				it.client_id  = PID_W'($urandom);
			end
			send_item(it);
		end
	endtask

	// reset defaults: ticks silent while off, then the default limit and cap
	task automatic test_reset_defaults();
		send_ping(20'd1000, 8'd3);
		send_ping(20'd998, 8'd9);
		send_tick(5'd1, 20'd1003);
		settle();
		write_reg(CFG_ENABLE, CFG_DATA_W'(1));
		send_tick(5'd1, 20'd1003);
		send_tick(5'd2, 20'd1006);
		send_tick(5'd3, 20'd1020);
	endtask

	// hand-picked corners at limit 10, cap 1200 (knee 5, buffer 5)
	task automatic test_directed_cases();
		send_tick(5'd4, 20'd100);          // nobody tracked, day latch kept
		send_ping(20'd100, 8'd7);          // empty tracker takes it
		send_ping(20'hFFFFF, 8'd255);      // newer day from another player
		send_tick(5'd3, 20'd105);          // same day as latched
		send_tick(5'd4, 20'd104);          // under the knee
		send_ping(20'd102, 8'd7);          // laggard moves ahead
		send_tick(5'd5, 20'd107);          // right at the knee
		send_tick(5'd6, 20'd110);          // inside the buffer
		send_tick(5'd7, 20'd112);          // full buffer, saturates
		send_tick(5'd31, 20'd95);          // game behind the laggard
		send_ping(20'd50, 8'd0);           // older day wins
		send_tick(5'd0, 20'd61);           // one past the limit clears
		send_ping(20'd0, 8'd255);
		send_tick(5'd1, 20'hFFFFF);        // huge lag clears
		send_ping(20'hFFFFF, 8'h55);
		send_tick(5'd2, 20'hFFFFF);        // zero lag
		send_ping(20'hFFFFE, 8'hAA);
		send_tick(5'd3, 20'd0);            // far negative lag
		send_ping(20'd0, 8'd0);
	endtask

	// limit and cap extremes, the sleep threshold, and a disabled stretch
	task automatic test_config_extremes();
		world_day = 20'($urandom);
		cur_mday  = MDAY_W'($urandom);
		set_config(1'b1, 10'd0, 16'hFFFF);
		play_round(35, 5);
		set_config(1'b1, 10'd1, 16'd1);
		play_round(35, 5);
		set_config(1'b1, 10'd2, 16'd5);   // penalty stops just short of sleeping
		play_round(35, 5);
		set_config(1'b1, 10'd2, 16'd6);   // penalty just reaches sleeping
		play_round(35, 5);
		set_config(1'b1, 10'd3, 16'd0);
		play_round(35, 5);
		set_config(1'b1, 10'd1023, 16'hFFFF);
		play_round(35, 5);
		set_config(1'b1, 10'd512, 16'd40000);
		play_round(35, 5);
		// pings still tracked while off
		set_config(1'b0, 10'd20, 16'd1200);
		play_round(35, 5);
	endtask

	// random settings, mostly small limits so lag sweeps the whole curve
	task automatic test_random_game();
		logic [LIMIT_W-1:0] limit;
		for (int p = 0; p < 4; p++) begin
			if ($urandom_range(0, 1) == 0)
				limit = LIMIT_W'($urandom_range(2, 40));
			else
				limit = LIMIT_W'($urandom_range(0, 1023));
			set_config(1'b1, limit, PEN_W'($urandom));
			play_round(120, 10);
		end
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		set_config(1'b1, 10'd16, 16'd3000);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		play_round(150, 5);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// receiver blocks for a long stretch while the sender keeps pushing
	task automatic test_backpressure();
		set_config(1'b1, 10'd12, 16'd2500);
		tx_steady = 1'b1;
		rx_hold   = HOLD_CYCLES;
		play_round(80, 0);
		tx_steady = 1'b0;
		// sender goes quiet until every decision has drained
		settle();
		play_round(40, 10);
	endtask

	// arbitrary field values throughout
	task automatic test_noise();
		set_config(1'b1, LIMIT_W'($urandom_range(0, 1023)), PEN_W'($urandom));
		play_round(120, 100);
	endtask

	// receiver: random ready, a steady mode, and a counted hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= rx_steady || ($urandom_range(0, 2) != 0);
		end
	end

	// compare every result transfer with the oldest pending decision
	always @(posedge clk) begin : check_results
		throttle_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_throttle.size() == 0) begin
				report_mismatch("unexpected result, penalty_ms", -1, result_ch.penalty_ms);
			end else begin
				want = expected_throttle.pop_front();
				if (result_ch.penalty_ms !== want.penalty_ms)
					report_mismatch("penalty_ms", want.penalty_ms, result_ch.penalty_ms);
				if (result_ch.sleep_now !== want.sleep_now)
					report_mismatch("sleep_now", want.sleep_now, result_ch.sleep_now);
				if (result_ch.tracker_cleared !== want.tracker_cleared)
					report_mismatch("tracker_cleared", want.tracker_cleared,
						result_ch.tracker_cleared);
				if (result_ch.lagging_player !== want.lagging_player)
					report_mismatch("lagging_player", want.lagging_player,
						result_ch.lagging_player);
			end
		end
	end

	// hang detector: counts cycles without a transfer on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
					(result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
		$display("lag_throttle_controller_unit_tb: FAIL");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_index          = CFG_ENABLE;
		cfg_data           = '0;
		item_ch.valid      = 1'b0;
		item_ch.op         = OP_PING;
		item_ch.report_day = '0;
		item_ch.client_id  = '0;
		item_ch.month_day  = '0;
		item_ch.total_days = '0;
		result_ch.ready    = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_directed_cases();
		test_config_extremes();
		test_random_game();
		test_back_to_back();
		test_backpressure();
		test_noise();

		// drain and let any trailing work finish
		settle();
		if (mismatch_count == 0) begin
			$display("lag_throttle_controller_unit_tb: PASS");
		end else begin
			$display("lag_throttle_controller_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
